>>> hw/rtl/pcg_pkg.sv
`timescale 1ns / 1ps

package pcg_pkg;

  localparam int SIZE_W     = 11;
  localparam int COMP_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int VAL_W      = FRAC_W + 1;
  localparam int W_NUM_W    = SIZE_W + FRAC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ENTRIES_W  = 5;
  localparam int COLOR_W    = 8;
  localparam int HSV_STAGES = 5;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int INDEX_BITS_DEF  = 10;

  localparam logic [VAL_W-1:0]  ONE         = VAL_W'(1) << FRAC_W;
  localparam logic [COMP_W-1:0] GREY_BASE   = 16'd6554;
  localparam logic [COMP_W-1:0] GREY_SPAN   = 16'd58982;
  localparam logic [SIZE_W-1:0] PALETTE_DEF = 11'd256;
  localparam int                SEXTANTS    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_SIZE,
    REG_GREY_MODE,
    REG_TABLE_IS_HSV,
    REG_TABLE_ENTRIES
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_WHITE,
    KIND_BLACK,
    KIND_GREY,
    KIND_SWEEP,
    KIND_TABLE
  } kind_t;

  typedef struct packed {
    logic                wr;
    kind_t               kind;
    logic [SIZE_W-1:0]   ii;
    logic [COMP_W-1:0]   c0;
    logic [COMP_W-1:0]   c1;
    logic [COMP_W-1:0]   c2;
  } item_t;

  typedef struct packed {
    logic               hsv;
    logic [VAL_W-1:0]   x0;
    logic [VAL_W-1:0]   x1;
    logic [VAL_W-1:0]   x2;
  } color_t;

endpackage

>>> hw/rtl/palette_color_generator_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Taken when               Word
// command  in   start && !busy           operation, index, comp_first/second/third
// result   out  strobe (one cycle)       red, green, blue
// config   in   cfg_valid && cfg_ready   cfg_index, cfg_data
//
// One command per clock while busy is low. A lookup gives one result word;
// a table write gives none. A lookup passes three bit-per-stage dividers in
// series and then the multiply stages.
// Reset is synchronous; busy is high for one cycle after reset.
// The pipeline moves every cycle; the receiver cannot stall it.

module palette_color_generator_core #(
  parameter int TABLE_DEPTH = pcg_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = pcg_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [INDEX_BITS-1:0]             index,
  input  logic [pcg_pkg::COMP_W-1:0]        comp_first,
  input  logic [pcg_pkg::COMP_W-1:0]        comp_second,
  input  logic [pcg_pkg::COMP_W-1:0]        comp_third,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              strobe,
  output logic [pcg_pkg::COLOR_W-1:0]       red,
  output logic [pcg_pkg::COLOR_W-1:0]       green,
  output logic [pcg_pkg::COLOR_W-1:0]       blue
);

  import pcg_pkg::*;

  localparam int TW      = $clog2(TABLE_DEPTH);
  localparam int KW      = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;
  localparam int IT_W    = $bits(item_t);
  localparam int A_NUM_W = SIZE_W + TW;
  localparam int I_NUM_W = TW + SIZE_W;
  localparam int WPAY_W  = IT_W + 2 * TW;
  localparam int ROW_W   = 3 * COMP_W;
  localparam int PROD_W  = COMP_W + VAL_W;
  localparam int SUM_W   = PROD_W + 1;

  logic [SIZE_W-1:0]    palette_size;
  logic                 grey_mode;
  logic                 table_is_hsv;
  logic [ENTRIES_W-1:0] table_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size  <= PALETTE_DEF;
      grey_mode     <= 1'b0;
      table_is_hsv  <= 1'b0;
      table_entries <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PALETTE_SIZE:  palette_size  <= cfg_data;
        REG_GREY_MODE:     grey_mode     <= cfg_data[0];
        REG_TABLE_IS_HSV:  table_is_hsv  <= cfg_data[0];
        REG_TABLE_ENTRIES: table_entries <= cfg_data[ENTRIES_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign cfg_ready = ~busy;

  logic              accept;
  logic [KW-1:0]     kx;
  logic              slot_ok;
  item_t             item_next;
  logic              s0_v;
  item_t             s0_item;
  logic [TW-1:0]     e;
  logic [SIZE_W-1:0] d, span;

  assign accept  = start & ~busy;
  assign kx      = KW'(index);
  assign slot_ok = (32'(index) < TABLE_DEPTH);

  always_comb begin
    item_next.wr = operation;
    item_next.c0 = comp_first;
    item_next.c1 = comp_second;
    item_next.c2 = comp_third;
    item_next.ii = operation ? SIZE_W'(kx) : SIZE_W'(kx - KW'(2));
    priority if (kx == '0) begin
      item_next.kind = KIND_WHITE;
    end else if (kx == KW'(1) || kx >= KW'(palette_size)) begin
      item_next.kind = KIND_BLACK;
    end else if (grey_mode) begin
      item_next.kind = KIND_GREY;
    end else if (table_entries <= ENTRIES_W'(1)) begin
      item_next.kind = KIND_SWEEP;
    end else begin
      item_next.kind = KIND_TABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= accept & (~operation | slot_ok);
    end
  end

  always_ff @(posedge clk) begin
    s0_item <= item_next;
  end

  always_comb begin
    if (32'(table_entries) >= TABLE_DEPTH) begin
      e = TW'(TABLE_DEPTH - 1);
    end else begin
      e = TW'(table_entries - ENTRIES_W'(1));
    end
    d    = palette_size - SIZE_W'(2);
    span = palette_size - SIZE_W'(3);
  end

  // j0 = i * e / d
  logic          a_v;
  logic [TW-1:0] a_q;
  item_t         a_item;

  pcg_div #(
    .NUM_W(A_NUM_W), .DEN_W(SIZE_W), .Q_W(TW), .PAY_W(IT_W)
  ) u_div_seg (
    .clk(clk), .rst(rst), .in_v(s0_v),
    .num(A_NUM_W'(s0_item.ii) * A_NUM_W'(e)), .den(d), .pay_in(s0_item),
    .out_v(a_v), .quo(a_q), .pay_out(a_item)
  );

  // i0 = j0 * d / e, i1 = j1 * d / e
  logic [TW-1:0]     a_j1;
  logic              b_v;
  logic [SIZE_W-1:0] b_i0, b_i1;
  item_t             b_item;
  logic [2*TW-1:0]   b_j;

  assign a_j1 = a_q + TW'(1);

  pcg_div #(
    .NUM_W(I_NUM_W), .DEN_W(TW), .Q_W(SIZE_W), .PAY_W(IT_W)
  ) u_div_lo (
    .clk(clk), .rst(rst), .in_v(a_v),
    .num(I_NUM_W'(a_q) * I_NUM_W'(d)), .den(e), .pay_in(a_item),
    .out_v(b_v), .quo(b_i0), .pay_out(b_item)
  );

  pcg_div #(
    .NUM_W(I_NUM_W), .DEN_W(TW), .Q_W(SIZE_W), .PAY_W(2 * TW)
  ) u_div_hi (
    .clk(clk), .rst(rst), .in_v(a_v),
    .num(I_NUM_W'(a_j1) * I_NUM_W'(d)), .den(e), .pay_in({a_q, a_j1}),
    .out_v(), .quo(b_i1), .pay_out(b_j)
  );

  // weight, grey ramp term or sweep hue
  logic [W_NUM_W-1:0] w_num;
  logic [SIZE_W-1:0]  w_den;
  logic               w_v;
  logic [VAL_W-1:0]   w_q;
  logic [WPAY_W-1:0]  w_pay;
  item_t              w_item;
  logic [TW-1:0]      w_j0, w_j1;

  always_comb begin
    case (b_item.kind)
      KIND_GREY: begin
        w_num = W_NUM_W'(b_item.ii) * W_NUM_W'(GREY_SPAN);
        w_den = span;
      end
      KIND_SWEEP: begin
        w_num = {b_item.ii, {FRAC_W{1'b0}}};
        w_den = d;
      end
      KIND_TABLE: begin
        w_num = {b_i1 - b_item.ii, {FRAC_W{1'b0}}};
        w_den = b_i1 - b_i0;
      end
      default: begin
        w_num = '0;
        w_den = '0;
      end
    endcase
  end

  pcg_div #(
    .NUM_W(W_NUM_W), .DEN_W(SIZE_W), .Q_W(VAL_W), .PAY_W(WPAY_W)
  ) u_div_wt (
    .clk(clk), .rst(rst), .in_v(b_v),
    .num(w_num), .den(w_den), .pay_in({b_item, b_j}),
    .out_v(w_v), .quo(w_q), .pay_out(w_pay)
  );

  assign w_item = item_t'(w_pay[WPAY_W-1:2*TW]);
  assign w_j0   = w_pay[2*TW-1:TW];
  assign w_j1   = w_pay[TW-1:0];

  // table writes land here too, so they stay in order with lookups
  logic             tbl_we;
  logic [ROW_W-1:0] tbl_wdata, rd0, rd1;

  assign tbl_we    = w_v & w_item.wr;
  assign tbl_wdata = {w_item.c0, w_item.c1, w_item.c2};

  pcg_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_ram_lo (
    .clk(clk), .we(tbl_we), .waddr(w_item.ii[TW-1:0]), .wdata(tbl_wdata),
    .raddr(w_j0), .rdata(rd0)
  );

  pcg_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_ram_hi (
    .clk(clk), .we(tbl_we), .waddr(w_item.ii[TW-1:0]), .wdata(tbl_wdata),
    .raddr(w_j1), .rdata(rd1)
  );

  logic             s4_v;
  kind_t            s4_kind;
  logic [VAL_W-1:0] s4_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= w_v & ~w_item.wr;
    end
  end

  always_ff @(posedge clk) begin
    s4_kind <= w_item.kind;
    s4_w    <= w_q;
  end

  // blend products
  logic [COMP_W-1:0] ca [3];
  logic [COMP_W-1:0] cb [3];
  logic [VAL_W-1:0]  w1;
  logic [PROD_W-1:0] p0_next [3];
  logic [PROD_W-1:0] p1_next [3];

  assign ca[0] = rd0[3*COMP_W-1:2*COMP_W];
  assign ca[1] = rd0[2*COMP_W-1:COMP_W];
  assign ca[2] = rd0[COMP_W-1:0];
  assign cb[0] = rd1[3*COMP_W-1:2*COMP_W];
  assign cb[1] = rd1[2*COMP_W-1:COMP_W];
  assign cb[2] = rd1[COMP_W-1:0];
  assign w1    = ONE - s4_w;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p0_next[ch] = PROD_W'(ca[ch]) * PROD_W'(s4_w);
      p1_next[ch] = PROD_W'(cb[ch]) * PROD_W'(w1);
    end
  end

  logic              s5_v;
  kind_t             s5_kind;
  logic [VAL_W-1:0]  s5_w;
  logic              s5_hsv;
  logic [PROD_W-1:0] s5_p0 [3];
  logic [PROD_W-1:0] s5_p1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    s5_kind <= s4_kind;
    s5_w    <= s4_w;
    s5_hsv  <= table_is_hsv;
    s5_p0   <= p0_next;
    s5_p1   <= p1_next;
  end

  logic [VAL_W-1:0] m [3];
  logic [VAL_W-1:0] grey;
  color_t           col;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      m[ch] = VAL_W'((SUM_W'(s5_p0[ch]) + SUM_W'(s5_p1[ch])
                      + (SUM_W'(1) << (FRAC_W - 1))) >> FRAC_W);
    end
  end

  assign grey = VAL_W'(GREY_BASE) + s5_w;

  always_comb begin
    case (s5_kind)
      KIND_WHITE: begin
        col.hsv = 1'b0; col.x0 = ONE; col.x1 = ONE; col.x2 = ONE;
      end
      KIND_GREY: begin
        col.hsv = 1'b0; col.x0 = grey; col.x1 = grey; col.x2 = grey;
      end
      KIND_SWEEP: begin
        col.hsv = 1'b1; col.x0 = s5_w; col.x1 = ONE; col.x2 = ONE;
      end
      KIND_TABLE: begin
        col.hsv = s5_hsv; col.x0 = m[0]; col.x1 = m[1]; col.x2 = m[2];
      end
      default: begin
        col.hsv = 1'b0; col.x0 = '0; col.x1 = '0; col.x2 = '0;
      end
    endcase
  end

  pcg_hsv u_hsv (
    .clk(clk), .rst(rst), .in_v(s5_v), .color(col),
    .out_v(strobe), .red(red), .green(green), .blue(blue)
  );

endmodule

>>> hw/rtl/pcg_ram.sv
`timescale 1ns / 1ps

module pcg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pcg_div.sv
`timescale 1ns / 1ps

module pcg_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11,
  parameter int Q_W   = 17,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_v,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay_in,
  output logic             out_v,
  output logic [Q_W-1:0]   quo,
  output logic [PAY_W-1:0] pay_out
);

  // quotient must fit Q_W bits, so the top bits start below den
  logic [Q_W:0]       v;
  logic [DEN_W-1:0]   rem [0:Q_W];
  logic [Q_W-1:0]     low [0:Q_W];
  logic [DEN_W-1:0]   dv  [0:Q_W];
  logic [PAY_W-1:0]   pay [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[Q_W-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= DEN_W'(num >> Q_W);
    low[0] <= num[Q_W-1:0];
    dv[0]  <= den;
    pay[0] <= pay_in;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {rem[s], low[s][Q_W-1]};
    assign ge = (t >= {1'b0, dv[s]});

    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? DEN_W'(t - {1'b0, dv[s]}) : DEN_W'(t);
      low[s+1] <= Q_W'({low[s], ge});
      dv[s+1]  <= dv[s];
      pay[s+1] <= pay[s];
    end
  end

  assign out_v   = v[Q_W];
  assign quo     = (dv[Q_W] == '0) ? '0 : low[Q_W];
  assign pay_out = pay[Q_W];

endmodule

>>> hw/rtl/pcg_hsv.sv
`timescale 1ns / 1ps

module pcg_hsv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_v,
  input  pcg_pkg::color_t               color,
  output logic                          out_v,
  output logic [pcg_pkg::COLOR_W-1:0]   red,
  output logic [pcg_pkg::COLOR_W-1:0]   green,
  output logic [pcg_pkg::COLOR_W-1:0]   blue
);

  import pcg_pkg::*;

  localparam int H6_W   = FRAC_W + 3;
  localparam int PROD_W = 2 * VAL_W;
  localparam int TO8_W  = VAL_W + 9;

  function automatic logic [COLOR_W-1:0] to8(input logic [VAL_W-1:0] x);
    logic [TO8_W-1:0] y;
    y = (TO8_W'(x) << 8) - TO8_W'(x) + (TO8_W'(1) << (FRAC_W - 1));
    if (y[TO8_W-1:FRAC_W] > 10'd255) begin
      to8 = '1;
    end else begin
      to8 = y[FRAC_W+COLOR_W-1:FRAC_W];
    end
  endfunction

  logic [HSV_STAGES-1:0] v;
  color_t                col1, col2, col3, col4;
  logic [2:0]            sext2, sext3, sext4;
  logic [FRAC_W-1:0]     f2;
  logic [VAL_W-1:0]      a3, b3, c3;
  logic [VAL_W-1:0]      p4, q4, t4;
  logic [H6_W-1:0]       h6;
  logic [PROD_W-1:0]     sf, sg;
  logic [VAL_W-1:0]      r_sel, g_sel, b_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[HSV_STAGES-2:0], in_v};
    end
  end

  assign h6 = H6_W'(col1.x0[FRAC_W-1:0]) * H6_W'(SEXTANTS);

  always_comb begin
    sf = PROD_W'(col2.x1) * PROD_W'(f2);
    sg = PROD_W'(col2.x1) * PROD_W'(ONE - VAL_W'(f2));
  end

  always_ff @(posedge clk) begin
    col1  <= color;
    col2  <= col1;
    sext2 <= h6[H6_W-1:FRAC_W];
    f2    <= h6[FRAC_W-1:0];
    col3  <= col2;
    sext3 <= sext2;
    a3    <= ONE - VAL_W'(sf >> FRAC_W);
    b3    <= ONE - VAL_W'(sg >> FRAC_W);
    c3    <= ONE - col2.x1;
    col4  <= col3;
    sext4 <= sext3;
    p4    <= VAL_W'((PROD_W'(col3.x2) * PROD_W'(c3)) >> FRAC_W);
    q4    <= VAL_W'((PROD_W'(col3.x2) * PROD_W'(a3)) >> FRAC_W);
    t4    <= VAL_W'((PROD_W'(col3.x2) * PROD_W'(b3)) >> FRAC_W);
  end

  always_comb begin
    r_sel = col4.x0;
    g_sel = col4.x1;
    b_sel = col4.x2;
    if (col4.hsv) begin
      unique case (sext4)
        3'd0: begin
          r_sel = col4.x2; g_sel = t4; b_sel = p4;
        end
        3'd1: begin
          r_sel = q4; g_sel = col4.x2; b_sel = p4;
        end
        3'd2: begin
          r_sel = p4; g_sel = col4.x2; b_sel = t4;
        end
        3'd3: begin
          r_sel = p4; g_sel = q4; b_sel = col4.x2;
        end
        3'd4: begin
          r_sel = t4; g_sel = p4; b_sel = col4.x2;
        end
        default: begin
          r_sel = col4.x2; g_sel = p4; b_sel = q4;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red   <= to8(r_sel);
    green <= to8(g_sel);
    blue  <= to8(b_sel);
  end

  assign out_v = v[HSV_STAGES-1];

endmodule

>>> hw/rtl/pcg_check.sv
`timescale 1ns / 1ps

module pcg_check #(
  parameter int TABLE_DEPTH = pcg_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic strobe
);

  import pcg_pkg::*;

  localparam int LAT = 1 + (1 + $clog2(TABLE_DEPTH)) + (1 + SIZE_W) + (1 + VAL_W) + 2
                       + HSV_STAGES;
  localparam int CW  = $clog2(LAT + 1);
  localparam logic [CW-1:0] LAT_C = CW'(LAT);

  logic          lookup;
  logic [CW-1:0] cnt;

  assign lookup = start && !busy && !operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt != LAT_C) begin
      cnt <= cnt + CW'(1);
    end
  end

  // one word out per lookup, fixed latency, none for writes
  a_result_per_lookup: assert property (@(posedge clk) disable iff (rst)
    (cnt == LAT_C) |-> (strobe == $past(lookup, LAT)))
    else $error("result word does not match accepted lookup");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> (busy && !strobe))
    else $error("pipeline not flushed by reset");

  a_busy_release: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy held after reset");

endmodule

bind palette_color_generator_core pcg_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_pcg_check (.*);
